[rtl/stw_pkg.sv]
// Shared constants for the scrolling text window: opcodes, register indexes,
// window geometry and delay limits.
// No dependencies.
package stw_pkg;

  // Default character store depth
  localparam int TEXT_MAX_DEF = 64;

  // Window geometry (window_pos is a 4-bit field, so the window is fixed at 16)
  localparam int WINDOW_WIDTH = 16;
  localparam int WIN_W        = $clog2(WINDOW_WIDTH);

  // Delay limits and reset values
  localparam logic [9:0] DELAY_MAX    = 10'd800;
  localparam logic [9:0] STEP_DEFAULT = 10'd10;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Item opcodes
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_SHOW    = 3'd2;
  localparam logic [2:0] OP_STEP    = 3'd3;
  localparam logic [2:0] OP_FASTER  = 3'd4;
  localparam logic [2:0] OP_SLOWER  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_TEXT_CHARS     = 3'd0;
  localparam logic [2:0] REG_PAD_SPACES     = 3'd1;
  localparam logic [2:0] REG_SCROLL_FORWARD = 3'd2;
  localparam logic [2:0] REG_INITIAL_DELAY  = 3'd3;
  localparam logic [2:0] REG_SPEED_STEP     = 3'd4;

  // Result kinds
  localparam logic RESULT_WINDOW = 1'b0;
  localparam logic RESULT_DELAY  = 1'b1;

endpackage

[rtl/scrolling_text_window.sv]
// Scrolling text window: load, restart and ignored opcodes hold the input for 1 cycle and give
// no beat. Faster/slower: REPORT registers the report beat once the output is free; the input
// stalls until then. Show/step: REDUCE subtracts the length k times, k = index div length (0
// unless the index is stale, at most 127); EMIT then gives 16 window beats at one per cycle
// while the output does not stall. The input stalls until the last beat is registered.
// Reset (synchronous) clears index and delay, restores register defaults; store is not cleared.
// Depends on stw_pkg.
module scrolling_text_window #(
  parameter int TEXT_MAX = stw_pkg::TEXT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [5:0] load_pos,
  input  logic [7:0] load_char,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] window_char,
  output logic [3:0] window_pos,
  output logic       last,
  output logic [9:0] delay_ms,
  output logic       delay_ok
);

  localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  // text length usable from the 7-bit register, capped by the store depth
  localparam logic [7:0] TEXT_CAP = (TEXT_MAX > 127) ? 8'd127 : 8'(TEXT_MAX);

  typedef enum logic [1:0] {IDLE, REDUCE, EMIT, REPORT} state_t;

  state_t      state;
  logic [6:0]  text_chars;
  logic [3:0]  pad_spaces;
  logic        scroll_forward;
  logic [9:0]  speed_step;
  logic [6:0]  scroll_index;
  logic [9:0]  scroll_delay;
  logic        pend_ok;
  logic [7:0]  text_pos;
  logic [stw_pkg::WIN_W-1:0] beat_cnt;

  logic [7:0]  char_store [TEXT_MAX];

  logic        in_take;
  logic        out_free;
  logic [7:0]  used_len;
  logic [7:0]  total_len;
  logic [7:0]  unit_in;
  logic        unit_ge;
  logic [7:0]  unit_out;
  logic [6:0]  step_index;
  logic [7:0]  idx_inc;
  logic [10:0] delay_sum;
  logic        slow_over;
  logic        fast_under;
  logic        is_text;
  logic        last_beat;
  logic [AW-1:0] rd_addr;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  // Lengths of the text and of text plus padding
  assign used_len  = ({1'b0, text_chars} > TEXT_CAP) ? TEXT_CAP : {1'b0, text_chars};
  assign total_len = used_len + {4'd0, pad_spaces};

  // Shared wrap unit: reduces the start position, then advances it per beat
  assign unit_in  = (state == EMIT) ? text_pos + 8'd1 : text_pos;
  assign unit_ge  = (unit_in >= total_len);
  assign unit_out = unit_ge ? unit_in - total_len : unit_in;

  // Next scroll index for a step item
  assign idx_inc = {1'b0, scroll_index} + 8'd1;
  always_comb begin
    if (total_len == 8'd0) begin
      step_index = 7'd0;
    end else if (scroll_forward) begin
      step_index = (idx_inc >= total_len) ? 7'd0 : idx_inc[6:0];
    end else if ((scroll_index == 7'd0) || ({1'b0, scroll_index} >= total_len)) begin
      step_index = 7'(total_len - 8'd1);
    end else begin
      step_index = scroll_index - 7'd1;
    end
  end

  // Delay adjustment checks
  assign delay_sum  = {1'b0, scroll_delay} + {1'b0, speed_step};
  assign slow_over  = (delay_sum > {1'b0, stw_pkg::DELAY_MAX});
  assign fast_under = (scroll_delay < speed_step);

  // Window character lookup
  assign is_text   = (text_pos < used_len);
  assign rd_addr   = AW'(text_pos);
  assign last_beat = (beat_cnt == stw_pkg::WIN_W'(stw_pkg::WINDOW_WIDTH - 1));

  // Character store writes
  always_ff @(posedge clk) begin
    if (in_take && (opcode == stw_pkg::OP_LOAD) && (32'(load_pos) < TEXT_MAX)) begin
      char_store[AW'(load_pos)] <= load_char;
    end
  end

  // Sequencer, state registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      out_valid      <= 1'b0;
      text_chars     <= 7'd0;
      pad_spaces     <= 4'd0;
      scroll_forward <= 1'b1;
      speed_step     <= stw_pkg::STEP_DEFAULT;
      scroll_index   <= 7'd0;
      scroll_delay   <= 10'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_take) begin
            case (opcode)
              stw_pkg::OP_RESTART: begin
                scroll_index <= 7'd0;
              end
              stw_pkg::OP_SHOW: begin
                text_pos <= {1'b0, scroll_index};
                state    <= REDUCE;
              end
              stw_pkg::OP_STEP: begin
                scroll_index <= step_index;
                text_pos     <= {1'b0, step_index};
                state        <= REDUCE;
              end
              stw_pkg::OP_FASTER: begin
                scroll_delay <= fast_under ? 10'd0 : scroll_delay - speed_step;
                pend_ok      <= !fast_under;
                state        <= REPORT;
              end
              stw_pkg::OP_SLOWER: begin
                scroll_delay <= slow_over ? stw_pkg::DELAY_MAX : delay_sum[9:0];
                pend_ok      <= !slow_over;
                state        <= REPORT;
              end
              default: begin
              end
            endcase
          end
        end

        // bring the start position below the total length
        REDUCE: begin
          if (unit_ge && (total_len != 8'd0)) begin
            text_pos <= unit_out;
          end else begin
            beat_cnt <= '0;
            state    <= EMIT;
          end
        end

        // one window character per beat
        EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= stw_pkg::RESULT_WINDOW;
            window_char <= is_text ? char_store[rd_addr] : stw_pkg::SPACE_CHAR;
            window_pos  <= 4'(beat_cnt);
            last        <= last_beat;
            delay_ms    <= 10'd0;
            delay_ok    <= 1'b0;
            text_pos    <= unit_out;
            beat_cnt    <= beat_cnt + 1'b1;
            if (last_beat) begin
              state <= IDLE;
            end
          end
        end

        REPORT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= stw_pkg::RESULT_DELAY;
            window_char <= 8'd0;
            window_pos  <= 4'd0;
            last        <= 1'b1;
            delay_ms    <= scroll_delay;
            delay_ok    <= pend_ok;
            state       <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          stw_pkg::REG_TEXT_CHARS:     text_chars     <= cfg_data[6:0];
          stw_pkg::REG_PAD_SPACES:     pad_spaces     <= cfg_data[3:0];
          stw_pkg::REG_SCROLL_FORWARD: scroll_forward <= cfg_data[0];
          stw_pkg::REG_INITIAL_DELAY: begin
            scroll_delay <= (cfg_data > stw_pkg::DELAY_MAX) ? stw_pkg::DELAY_MAX : cfg_data;
          end
          stw_pkg::REG_SPEED_STEP:     speed_step     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Checks
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    scroll_delay <= stw_pkg::DELAY_MAX)
    else $error("scroll delay above limit");

  a_window_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == stw_pkg::RESULT_WINDOW) |->
      (last == (window_pos == 4'(stw_pkg::WINDOW_WIDTH - 1))))
    else $error("window last flag not on final position");

  a_report_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == stw_pkg::RESULT_DELAY) |->
      last && (window_char == 8'd0) && (window_pos == 4'd0))
    else $error("delay report carries window fields");

  a_step_index: assert property (@(posedge clk) disable iff (rst)
    $past(in_take && (opcode == stw_pkg::OP_STEP)) && !$past(cfg_we) &&
      (total_len != 8'd0) && (total_len <= 8'd128) |->
      ({1'b0, scroll_index} < total_len))
    else $error("scroll index not below length after step");

endmodule
